[hw/rtl/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    localparam logic [7:0] GPS_RESET = 8'd15;
    localparam logic [6:0] CHAR_PAD   = 7'h3D;
    localparam logic [6:0] CHAR_SPACE = 7'h20;

    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } pad_t;

    // one group of work for the back end
    typedef struct packed {
        logic [23:0] word;
        pad_t        pad;
        logic        space;
        logic        last;
    } b64e_job_t;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        begin
            if (v < 6'd26) begin
                c = 7'h41 + {1'b0, v};
            end else if (v < 6'd52) begin
                c = 7'h61 + {1'b0, v - 6'd26};
            end else if (v < 6'd62) begin
                c = 7'h30 + {1'b0, v - 6'd52};
            end else if (v == 6'd62) begin
                c = 7'h2B;
            end else begin
                c = 7'h2F;
            end
            return c;
        end
    endfunction

endpackage

[hw/rtl/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front
// Collects bytes into groups of three, tracks spacing, issues group jobs.
// ----------------------------------------------------------------------------
module b64e_front
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    output logic        job_push,
    output b64e_job_t   job
);

    logic [7:0]  gps_reg;
    logic [15:0] pend_reg, pend_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  gss_reg, gss_next;

    logic [7:0] limit;
    logic [7:0] gss_inc;
    logic       space_hit;

    assign limit     = (gps_reg == 8'd0) ? 8'd1 : gps_reg;
    assign gss_inc   = gss_reg + 8'd1;
    assign space_hit = (gss_inc >= limit) || (gss_inc == 8'd0);

    always_comb
    begin
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        gss_next   = gss_reg;
        job_push   = 1'b0;
        job.word   = {pend_reg, data_byte};
        job.pad    = PAD_NONE;
        job.space  = 1'b0;
        job.last   = final_byte;
        if (accept)
        begin
            if (cnt_reg >= 2'd2)
            begin
                job_push  = 1'b1;
                job.space = space_hit;
                gss_next  = space_hit ? 8'd0 : gss_inc;
                pend_next = 16'd0;
                cnt_next  = 2'd0;
            end
            else if (final_byte)
            begin
                job_push = 1'b1;
                if (cnt_reg == 2'd1)
                begin
                    job.word = {pend_reg[7:0], data_byte, 8'd0};
                    job.pad  = PAD_ONE;
                end
                else
                begin
                    job.word = {data_byte, 16'd0};
                    job.pad  = PAD_TWO;
                end
            end
            else
            begin
                pend_next = {pend_reg[7:0], data_byte};
                cnt_next  = cnt_reg + 2'd1;
            end
            if (final_byte)
            begin
                pend_next = 16'd0;
                cnt_next  = 2'd0;
                gss_next  = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gps_reg  <= GPS_RESET;
            pend_reg <= 16'd0;
            cnt_reg  <= 2'd0;
            gss_reg  <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                gps_reg <= cfg_data;
            end
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            gss_reg  <= gss_next;
        end
    end

endmodule

[hw/rtl/b64e_queue.sv]
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module b64e_queue
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  b64e_job_t   push_job,
    input  logic        pop,
    output b64e_job_t   head_job,
    output logic        q_full,
    output logic        q_empty
);

    b64e_job_t              slots_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [JOB_CNT_W-1:0]   cnt_reg;

    logic do_push, do_pop;

    assign q_full   = (cnt_reg == JOB_CNT_W'(JOB_DEPTH));
    assign q_empty  = (cnt_reg == '0);
    assign do_push  = push && !q_full;
    assign do_pop   = pop && !q_empty;
    assign head_job = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + JOB_CNT_W'(do_push) - JOB_CNT_W'(do_pop);
        end
    end

endmodule

[hw/rtl/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back
// Steps a group job one char per cycle into the output reg unless stalled.
// ----------------------------------------------------------------------------
module b64e_back
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  b64e_job_t   job,
    input  logic        job_valid,
    output logic        job_pop,
    input  logic        pop,
    output logic        empty,
    output logic [6:0]  out_char,
    output logic        run_end,
    output logic        message_end
);

    logic [2:0] idx_reg, idx_next;
    logic       ovalid_reg, ovalid_next;
    logic [6:0] char_reg;
    logic       run_end_reg, msg_end_reg;

    logic       load;
    logic       is_last;
    logic [2:0] pad_start;
    logic [5:0] sext;
    logic [6:0] char_cur;

    assign load      = job_valid && (!ovalid_reg || pop);
    assign is_last   = job.space ? (idx_reg == 3'd4) : (idx_reg == 3'd3);
    assign pad_start = 3'd4 - {1'b0, job.pad};
    assign job_pop   = load && is_last;

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    sext = job.word[23:18];
            2'd1:    sext = job.word[17:12];
            2'd2:    sext = job.word[11:6];
            default: sext = job.word[5:0];
        endcase
        if (idx_reg == 3'd4)
        begin
            char_cur = CHAR_SPACE;
        end
        else if (idx_reg >= pad_start)
        begin
            char_cur = CHAR_PAD;
        end
        else
        begin
            char_cur = b64_char(sext);
        end
    end

    always_comb
    begin
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg;
        if (pop && ovalid_reg)
        begin
            ovalid_next = 1'b0;
        end
        if (load)
        begin
            ovalid_next = 1'b1;
            idx_next    = is_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg    <= char_cur;
            run_end_reg <= is_last;
            msg_end_reg <= is_last && job.last;
        end
    end

    assign empty       = !ovalid_reg;
    assign out_char    = char_reg;
    assign run_end     = run_end_reg;
    assign message_end = msg_end_reg;

endmodule

[hw/rtl/base64_encoder.sv]
// Path: the byte that completes a group is written as a job into the queue;
// the back end then loads its first character into the output register.
// Throughput: one character per cycle from the back end's output register
// while the receiver pops; three bytes give four or five characters.
// Reset: asynchronous, clears pending bytes, spacing count and the queue;
// groups_per_space returns to 15.
// ----------------------------------------------------------------------------
// base64_encoder
// Byte stream to Base64 text with spacing and '=' padding.
// ----------------------------------------------------------------------------
module base64_encoder
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  out_char,
    output logic        run_end,
    output logic        message_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic      accept;
    logic      job_push;
    b64e_job_t push_job;
    b64e_job_t head_job;
    logic      q_empty;
    logic      job_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .job_push   (job_push),
        .job        (push_job)
    );

    b64e_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .q_full   (full),
        .q_empty  (q_empty)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (head_job),
        .job_valid   (!q_empty),
        .job_pop     (job_pop),
        .pop         (pop),
        .empty       (empty),
        .out_char    (out_char),
        .run_end     (run_end),
        .message_end (message_end)
    );

endmodule

[hw/rtl/b64e_checker.sv]
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the Base64 encoder result stream.
// ----------------------------------------------------------------------------
module b64e_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [6:0]  out_char,
    input  logic        run_end,
    input  logic        message_end
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result beat visible during reset");

    a_msg_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && message_end) |-> run_end)
        else $error("message_end without run_end");

    a_space_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_char == 7'h20) |-> run_end)
        else $error("space not last of its run");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((out_char >= 7'h41 && out_char <= 7'h5A) ||
                    (out_char >= 7'h61 && out_char <= 7'h7A) ||
                    (out_char >= 7'h30 && out_char <= 7'h39) ||
                    out_char == 7'h2B || out_char == 7'h2F ||
                    out_char == 7'h3D || out_char == 7'h20))
        else $error("character outside alphabet");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(run_end)))
        else $error("stalled result beat changed");

endmodule

bind base64_encoder b64e_checker u_b64e_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .run_end     (run_end),
    .message_end (message_end)
);

[dv/base64_encoder_tb.sv]
// ----------------------------------------------------------------------------
// base64_encoder_tb
// Streams byte messages into the encoder under several spacing settings and
// idle patterns, and checks every character beat against a cycle-free
// predictor of the Base64 text, spacing and padding.
// ----------------------------------------------------------------------------
module base64_encoder_tb;
    import b64e_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } byte_item_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       run_end;
        logic       msg_end;
    } char_beat_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] data_byte;
    logic       final_byte;
    logic       empty;
    logic       pop;
    logic [6:0] out_char;
    logic       run_end;
    logic       message_end;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    byte_item_t byte_q[$];
    char_beat_t expected_chars[$];

    int  bytes_total;
    int  bytes_in;
    int  fail_count;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  msg_left;
    bit  in_took;

    // predictor state
    logic [7:0]  spacing;
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    logic [7:0]  run_groups;

    base64_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .final_byte  (final_byte),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .run_end     (run_end),
        .message_end (message_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
            fail_count++;
        end
    endtask

    // works out the characters one accepted byte causes
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [6:0]  chars [0:4];
        logic [23:0] word;
        logic [7:0]  limit;
        char_beat_t  beat;
        int          n;
        int          k;
        begin
            n = 0;
            if (held_count >= 2'd2)
            begin
                word  = {held_bytes, b};
                limit = (spacing == 8'd0) ? 8'd1 : spacing;
                for (k = 0; k < 4; k++)
                begin
                    chars[k] = 7'(alphabet[word[18 - 6 * k +: 6]]);
                end
                n = 4;
                run_groups = run_groups + 8'd1;
                if (run_groups >= limit || run_groups == 8'd0)
                begin
                    run_groups = 8'd0;
                    chars[4]   = CHAR_SPACE;
                    n          = 5;
                end
                held_bytes = 16'd0;
                held_count = 2'd0;
            end
            else if (fin)
            begin
                if (held_count == 2'd1)
                begin
                    word     = {held_bytes[7:0], b, 8'h00};
                    chars[2] = 7'(alphabet[word[11:6]]);
                end
                else
                begin
                    word     = {b, 16'h0000};
                    chars[2] = CHAR_PAD;
                end
                chars[0] = 7'(alphabet[word[23:18]]);
                chars[1] = 7'(alphabet[word[17:12]]);
                chars[3] = CHAR_PAD;
                n = 4;
            end
            else
            begin
                held_bytes = {held_bytes[7:0], b};
                held_count = held_count + 2'd1;
            end

            if (fin)
            begin
                held_bytes = 16'd0;
                held_count = 2'd0;
                run_groups = 8'd0;
            end

            for (k = 0; k < n; k++)
            begin
                beat.ch      = chars[k];
                beat.run_end = (k == n - 1);
                beat.msg_end = (k == n - 1) && fin;
                expected_chars.push_back(beat);
            end
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        byte_item_t item;
        begin
            item.data = b;
            item.fin  = fin;
            byte_q.push_back(item);
            bytes_total++;
        end
    endtask

    // random messages; mostly short, some long enough for several spaces
    task automatic queue_stream(input int n, input bit may_end);
        logic [7:0] b;
        int         i;
        begin
            for (i = 0; i < n; i++)
            begin
                if (msg_left == 0)
                begin
                    msg_left = ($urandom_range(9) == 0) ? $urandom_range(13, 45)
                                                        : $urandom_range(1, 12);
                end
                msg_left--;
                case ($urandom_range(7))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(255));
                endcase
                queue_byte(b, may_end && msg_left == 0);
            end
        end
    endtask

    task automatic wait_drained();
        begin
            while (bytes_in != bytes_total || expected_chars.size() != 0)
            begin
                @(negedge clk);
            end
        end
    endtask

    task automatic write_spacing(input logic [7:0] v);
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= v;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!push || in_took))
        begin
            if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                push       <= 1'b1;
                data_byte  <= byte_q[0].data;
                final_byte <= byte_q[0].fin;
                byte_q.pop_front();
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor, predictor update and watchdog
    always @(posedge clk)
    begin
        char_beat_t want;
        bit         moved;
        in_took <= push && !full;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                spacing = cfg_data;
                moved   = 1'b1;
            end
            if (push && !full)
            begin
                encode_byte(data_byte, final_byte);
                bytes_in++;
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (expected_chars.size() == 0)
                begin
                    report_mismatch("beat with nothing expected", out_char, 0);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch("out_char", out_char, want.ch);
                    if (run_end !== want.run_end)
                        report_mismatch("run_end", run_end, want.run_end);
                    if (message_end !== want.msg_end)
                        report_mismatch("message_end", message_end, want.msg_end);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int         p;
        int         n;
        logic [7:0] v;
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        data_byte      = 8'h00;
        final_byte     = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 8'h00;
        in_took        = 1'b0;
        bytes_total    = 0;
        bytes_in       = 0;
        fail_count     = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        msg_left       = 0;
        spacing        = GPS_RESET;
        held_bytes     = 16'd0;
        held_count     = 2'd0;
        run_groups     = 8'd0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: single and double leftovers, full groups, '+' and '/'
        @(posedge clk);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFB, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'hBE, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b1);
        queue_byte(8'h4D, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h6E, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b1);

        // phase with 255 leaves the message open so the next write lowers spacing
        for (p = 0; p < 7; p++)
        begin
            case (p)
                0: begin v = 8'd1;   n = 35; end
                1: begin v = 8'd0;   n = 30; end
                2: begin v = 8'd255; n = 30; end
                3: begin v = 8'd4;   n = 40; end
                4: begin v = 8'($urandom_range(5, 254)); n = 35; end
                5: begin v = 8'd2;   n = 25; end
                default: begin v = 8'd3; n = 30; end
            endcase
            write_spacing(v);
            @(posedge clk);
            case (p % 4)
                0: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                1: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                2: begin send_idle_pct = 32; recv_stall_pct = 32; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            queue_stream(n, p != 2);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_encoder.sv
hw/rtl/b64e_checker.sv
dv/base64_encoder_tb.sv
